>>> hw/rtl/qebm_pkg.sv
// ----------------------------------------------------------------------------
// qebm_pkg: shared types and constants for the embedding-bag mean unit
// Table sizes, derived widths, command codes and the command record that
// travels from the front end to the execution back end.
// ----------------------------------------------------------------------------
package qebm_pkg;

  // Table geometry and derived address widths.
  localparam int MAX_EMBED_SIZE = 64;
  localparam int MAX_BUCKETS    = 4096;
  localparam int ELEM_W         = $clog2(MAX_EMBED_SIZE);
  localparam int BKT_W          = $clog2(MAX_BUCKETS);
  localparam int ROWS_W         = $clog2(MAX_EMBED_SIZE + 1);
  localparam int EMB_DEPTH      = MAX_BUCKETS * MAX_EMBED_SIZE;

  // Stream payload widths.
  localparam int S_TDATA_W = 112;
  localparam int M_TDATA_W = 40;

  // Arithmetic widths: 9-bit difference times 32-bit scale, then the
  // magnitude shifted right by four divided by the feature count.
  localparam int PROD_W    = 41;
  localparam int DIV_STEPS = 35;
  localparam int TERM_W    = DIV_STEPS + 1;

  // Input opcodes.
  localparam logic [2:0] OP_WR_BYTE  = 3'd0;
  localparam logic [2:0] OP_WR_SCALE = 3'd1;
  localparam logic [2:0] OP_WR_ACC   = 3'd2;
  localparam logic [2:0] OP_ADD      = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  // Result status codes.
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_RANGE  = 2'd1;
  localparam logic [1:0] STS_LENGTH = 2'd2;
  localparam logic [1:0] STS_COUNT  = 2'd3;

  // Configuration register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_EMBED_SIZE  = 2'd0;
  localparam logic [1:0] REG_NUM_BUCKETS = 2'd1;
  localparam logic [1:0] REG_QUANT_BIAS  = 2'd2;

  // Work kinds after classification; rejected items become K_NONE.
  typedef enum logic [2:0] {
    K_NONE,
    K_WR_BYTE,
    K_WR_SCALE,
    K_WR_ACC,
    K_ADD,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [1:0]        status;
    logic [15:0]       bucket;
    logic [5:0]        elem;
    logic [7:0]        byte_value;
    logic [31:0]       value;
    logic [7:0]        count;
    logic [ROWS_W-1:0] rows;
  } cmd_t;

endpackage

>>> hw/rtl/qebm_ram.sv
// ----------------------------------------------------------------------------
// qebm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qebm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data registered; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/qebm_front.sv
// ----------------------------------------------------------------------------
// qebm_front: input acceptance, classification and command queue
// Unpacks each input transfer, runs the range, length and count checks and
// queues the resulting command in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module qebm_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [qebm_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic [6:0]                         embedding_size,
  input  logic [12:0]                        num_buckets,
  output logic                               head_valid,
  output qebm_pkg::cmd_t                     head,
  input  logic                               pop
);
  import qebm_pkg::*;

  logic [2:0]        f_opcode;
  logic [15:0]       f_bucket;
  logic [5:0]        f_elem;
  logic [7:0]        f_byte;
  logic [31:0]       f_scale;
  logic [31:0]       f_accum;
  logic [7:0]        f_count;
  logic [6:0]        f_dlen;
  logic              bucket_ok;
  logic              elem_ok;
  logic [16:0]       nb_eff;
  logic              add_bucket_bad;
  logic [ROWS_W-1:0] rows_eff;
  cmd_t              cmd;
  cmd_t              slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              push;

  // Field unpacking.
  assign f_opcode = s_tdata[2:0];
  assign f_bucket = s_tdata[18:3];
  assign f_elem   = s_tdata[24:19];
  assign f_byte   = s_tdata[32:25];
  assign f_scale  = s_tdata[64:33];
  assign f_accum  = s_tdata[96:65];
  assign f_count  = s_tdata[104:97];
  assign f_dlen   = s_tdata[111:105];

  // Range checks against the table geometry and the bucket register.
  assign bucket_ok = {16'd0, f_bucket} < 32'(MAX_BUCKETS);
  assign elem_ok   = {26'd0, f_elem} < 32'(MAX_EMBED_SIZE);
  assign nb_eff    = ({4'd0, num_buckets} > 17'(MAX_BUCKETS)) ? 17'(MAX_BUCKETS)
                                                              : {4'd0, num_buckets};
  assign add_bucket_bad = {1'b0, f_bucket} >= nb_eff;
  assign rows_eff  = ({25'd0, embedding_size} > 32'(MAX_EMBED_SIZE)) ?
                     ROWS_W'(MAX_EMBED_SIZE) : ROWS_W'(embedding_size);

  // Classification: failed checks turn into a plain status answer.
  always_comb begin
    cmd.kind       = K_NONE;
    cmd.status     = STS_OK;
    cmd.bucket     = f_bucket;
    cmd.elem       = f_elem;
    cmd.byte_value = f_byte;
    cmd.value      = f_accum;
    cmd.count      = f_count;
    cmd.rows       = rows_eff;
    unique case (f_opcode)
      OP_WR_BYTE: begin
        if (bucket_ok && elem_ok) cmd.kind = K_WR_BYTE;
        else cmd.status = STS_RANGE;
      end
      OP_WR_SCALE: begin
        cmd.value = f_scale;
        if (bucket_ok) cmd.kind = K_WR_SCALE;
        else cmd.status = STS_RANGE;
      end
      OP_WR_ACC: begin
        if (elem_ok) cmd.kind = K_WR_ACC;
        else cmd.status = STS_RANGE;
      end
      OP_ADD: begin
        if (f_dlen != embedding_size) cmd.status = STS_LENGTH;
        else if (f_count == 8'd0) cmd.status = STS_COUNT;
        else if (add_bucket_bad) cmd.status = STS_RANGE;
        else cmd.kind = K_ADD;
      end
      OP_READ: begin
        if (elem_ok) cmd.kind = K_READ;
        else cmd.status = STS_RANGE;
      end
      default: begin
        cmd.kind = K_NONE;
      end
    endcase
  end

  // Two-entry command queue.
  assign s_tready   = fill != 2'd2;
  assign push       = s_tvalid && s_tready;
  assign head_valid = fill != 2'd0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cmd;
  end

  // The back end never takes from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty command queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("command queue overfilled");

  a_fill_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fill == 2'($past(fill) + 2'd1))
    else $error("command queue count lost a transfer");

endmodule

>>> hw/rtl/qebm_back.sv
// ----------------------------------------------------------------------------
// qebm_back: command execution and result register
// Owns the embedding, scale and accumulator memories. Add-feature commands
// stream one element per cycle through a multiply stage, a pipelined
// restoring divider and a saturating read-modify-write of the accumulator.
// ----------------------------------------------------------------------------
module qebm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  qebm_pkg::cmd_t head,
  output logic           pop,
  input  logic [7:0]     quant_bias,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [1:0]     out_status,
  output logic [31:0]    out_value
);
  import qebm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCALE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  localparam int EMB_AW = BKT_W + ELEM_W;

  state_t             state;
  logic               out_free;
  logic               res_load;
  logic [BKT_W-1:0]   bucket_reg;
  logic [7:0]         count_reg;
  logic [ROWS_W-1:0]  rows_reg;
  logic [ELEM_W-1:0]  elem_reg;
  logic signed [31:0] scale_reg;
  logic [ROWS_W-1:0]  k_cnt;
  logic               issue;
  logic               pipe_busy;

  // Memory ports.
  logic               emb_we;
  logic [EMB_AW-1:0]  emb_waddr;
  logic [EMB_AW-1:0]  emb_raddr;
  logic [7:0]         emb_rdata;
  logic               scl_we;
  logic [31:0]        scl_rdata;
  logic               acc_we;
  logic [ELEM_W-1:0]  acc_waddr;
  logic [31:0]        acc_wdata;
  logic [ELEM_W-1:0]  acc_raddr;
  logic [31:0]        acc_rdata;
  logic [MAX_EMBED_SIZE-1:0] acc_vld;

  // Pipeline stages.
  logic                     e_valid;
  logic [ELEM_W-1:0]        e_k;
  logic                     m_valid;
  logic [ELEM_W-1:0]        m_k;
  logic signed [PROD_W-1:0] m_prod;
  logic signed [8:0]        diff;
  logic [PROD_W-1:0]        mag;
  logic [DIV_STEPS:0]       dv_valid;
  logic                     dv_neg [DIV_STEPS+1];
  logic [ELEM_W-1:0]        dv_k   [DIV_STEPS+1];
  logic [7:0]               dv_rem [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]     dv_q   [DIV_STEPS+1];
  logic [7:0]               nx_rem [DIV_STEPS];
  logic [DIV_STEPS-1:0]     nx_q   [DIV_STEPS];
  logic                     q_valid;
  logic [ELEM_W-1:0]        q_k;
  logic signed [TERM_W-1:0] q_term;
  logic [31:0]              old_val;
  logic [36:0]              sum;
  logic [31:0]              sum_sat;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == ST_IDLE) && head_valid && out_free;
  assign issue    = (state == ST_RUN);
  assign pipe_busy = e_valid || m_valid || (|dv_valid) || q_valid;

  // A result is loaded for plain commands at pop, after a read, or after the drain.
  assign res_load = (pop && head.kind != K_READ && head.kind != K_ADD) ||
                    (state == ST_READ) || (state == ST_DRAIN && !pipe_busy);

  // Embedding table.
  assign emb_we    = pop && (head.kind == K_WR_BYTE);
  assign emb_waddr = {head.bucket[BKT_W-1:0], ELEM_W'(head.elem)};
  assign emb_raddr = {bucket_reg, k_cnt[ELEM_W-1:0]};

  qebm_ram #(.WIDTH(8), .DEPTH(EMB_DEPTH)) u_emb_ram (
    .clk   (clk),
    .we    (emb_we),
    .waddr (emb_waddr),
    .wdata (head.byte_value),
    .raddr (emb_raddr),
    .rdata (emb_rdata)
  );

  // Scale table; the read follows the queue head so it is ready after pop.
  assign scl_we = pop && (head.kind == K_WR_SCALE);

  qebm_ram #(.WIDTH(32), .DEPTH(MAX_BUCKETS)) u_scl_ram (
    .clk   (clk),
    .we    (scl_we),
    .waddr (head.bucket[BKT_W-1:0]),
    .wdata (head.value),
    .raddr (head.bucket[BKT_W-1:0]),
    .rdata (scl_rdata)
  );

  // Accumulator: written by load commands or by the writeback stage.
  assign acc_we    = (pop && (head.kind == K_WR_ACC)) || q_valid;
  assign acc_waddr = q_valid ? q_k : ELEM_W'(head.elem);
  assign acc_wdata = q_valid ? sum_sat : head.value;
  assign acc_raddr = dv_valid[DIV_STEPS] ? dv_k[DIV_STEPS] : ELEM_W'(head.elem);

  qebm_ram #(.WIDTH(32), .DEPTH(MAX_EMBED_SIZE)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // Valid bits stand in for the reset value of the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
    end else if (acc_we) begin
      acc_vld[acc_waddr] <= 1'b1;
    end
  end

  // Multiply stage: signed byte difference times the bucket scale.
  assign diff = $signed({1'b0, emb_rdata}) - $signed({1'b0, quant_bias});
  assign mag  = m_prod[PROD_W-1] ? PROD_W'(-m_prod) : PROD_W'(m_prod);

  // One restoring division step per divider stage.
  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      logic [8:0] t;
      t = {dv_rem[i], dv_q[i][DIV_STEPS-1]};
      if (t >= {1'b0, count_reg}) begin
        nx_rem[i] = 8'(t - {1'b0, count_reg});
        nx_q[i]   = {dv_q[i][DIV_STEPS-2:0], 1'b1};
      end else begin
        nx_rem[i] = t[7:0];
        nx_q[i]   = {dv_q[i][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  // Writeback: add the signed term and saturate to 32 bits.
  assign old_val = acc_vld[q_k] ? acc_rdata : 32'd0;
  assign sum     = {{5{old_val[31]}}, old_val} + {q_term[TERM_W-1], q_term};
  always_comb begin
    if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) sum_sat = sum[31:0];
    else if (sum[36]) sum_sat = 32'h8000_0000;
    else sum_sat = 32'h7FFF_FFFF;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid  <= 1'b0;
      m_valid  <= 1'b0;
      dv_valid <= '0;
      q_valid  <= 1'b0;
    end else begin
      e_valid  <= issue;
      m_valid  <= e_valid;
      dv_valid <= {dv_valid[DIV_STEPS-1:0], m_valid};
      q_valid  <= dv_valid[DIV_STEPS];
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    e_k       <= k_cnt[ELEM_W-1:0];
    m_k       <= e_k;
    m_prod    <= diff * scale_reg;
    dv_k[0]   <= m_k;
    dv_neg[0] <= m_prod[PROD_W-1];
    dv_rem[0] <= 8'd0;
    dv_q[0]   <= mag[DIV_STEPS+3:4];
    for (int i = 0; i < DIV_STEPS; i++) begin
      dv_k[i+1]   <= dv_k[i];
      dv_neg[i+1] <= dv_neg[i];
      dv_rem[i+1] <= nx_rem[i];
      dv_q[i+1]   <= nx_q[i];
    end
    q_k    <= dv_k[DIV_STEPS];
    q_term <= dv_neg[DIV_STEPS] ? -$signed({1'b0, dv_q[DIV_STEPS]})
                                : $signed({1'b0, dv_q[DIV_STEPS]});
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      k_cnt    <= '0;
    end else begin
      if (res_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            elem_reg   <= ELEM_W'(head.elem);
            bucket_reg <= head.bucket[BKT_W-1:0];
            count_reg  <= head.count;
            rows_reg   <= head.rows;
            case (head.kind)
              K_READ: state <= ST_READ;
              K_ADD:  state <= ST_SCALE;
              default: begin
                out_status <= head.status;
                out_value  <= 32'd0;
              end
            endcase
          end
        end
        ST_READ: begin
          out_status <= STS_OK;
          out_value  <= acc_vld[elem_reg] ? acc_rdata : 32'd0;
          state      <= ST_IDLE;
        end
        ST_SCALE: begin
          scale_reg <= $signed(scl_rdata);
          k_cnt     <= '0;
          state     <= (rows_reg == '0) ? ST_DRAIN : ST_RUN;
        end
        ST_RUN: begin
          k_cnt <= k_cnt + 1'b1;
          if (k_cnt == rows_reg - 1'b1) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            out_status <= STS_OK;
            out_value  <= 32'd0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Writebacks only happen while an add-feature command is in progress.
  a_wb_in_add: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (state == ST_RUN || state == ST_DRAIN))
    else $error("accumulator writeback outside an add-feature command");

  // Element issue stays inside the row.
  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> k_cnt < rows_reg)
    else $error("element issued beyond the row length");

  // The result register is free whenever a late result is about to land.
  a_drain_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && !pipe_busy) |-> !m_tvalid)
    else $error("add-feature result would overwrite a pending result");

  a_read_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !m_tvalid)
    else $error("read result would overwrite a pending result");

endmodule

>>> hw/rtl/quantized_embedding_bag_mean_unit.sv
// ----------------------------------------------------------------------------
// quantized_embedding_bag_mean_unit: embedding-bag mean pooling engine
// Keeps a uint8 embedding table, per-bucket Q8.24 scales and a Q12.20
// accumulator; add-feature commands add the scaled row divided by the bag
// size to every accumulator element with saturation.
//
// Channel   Direction  Content
// s_*       in         one command per transfer (opcode and operands)
// m_*       out        one result per command (status, read value)
// APB       in/out     embedding_size, num_buckets, quant_bias registers
//
// Writes, loads, reads and rejected commands do not use the pipeline in the
// back end. In an add-feature command one element enters the multiply and
// 35-stage divider pipeline per cycle, and the back end waits for the
// pipeline to drain before the next command.
// Reset clears the command queue and accumulator valid bits and presets the
// registers; the tables are undefined until written. A two-entry queue takes
// new commands while the result register waits on m_tready.
// ----------------------------------------------------------------------------
module quantized_embedding_bag_mean_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // opcode, bucket, element_index, byte_value, scale_value, accum_value,
  // feature_count, dest_length
  input  logic [qebm_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status, read_value, zero fill
  output logic [qebm_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import qebm_pkg::*;

  logic [6:0]  embedding_size;
  logic [12:0] num_buckets;
  logic [7:0]  quant_bias;
  logic        head_valid;
  cmd_t        head;
  logic        pop;
  logic [1:0]  out_status;
  logic [31:0] out_value;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      embedding_size <= 7'd64;
      num_buckets    <= 13'd4096;
      quant_bias     <= 8'd128;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_EMBED_SIZE:  embedding_size <= pwdata[6:0];
        REG_NUM_BUCKETS: num_buckets    <= pwdata[12:0];
        REG_QUANT_BIAS:  quant_bias     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_EMBED_SIZE:  prdata = {25'd0, embedding_size};
      REG_NUM_BUCKETS: prdata = {19'd0, num_buckets};
      REG_QUANT_BIAS:  prdata = {24'd0, quant_bias};
      default:         prdata = 32'd0;
    endcase
  end

  qebm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .embedding_size (embedding_size),
    .num_buckets    (num_buckets),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop)
  );

  qebm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .quant_bias (quant_bias),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_status (out_status),
    .out_value  (out_value)
  );

  // Result packing: status in the low bits.
  assign m_tdata = {6'd0, out_value, out_status};

endmodule

>>> sim/quantized_embedding_bag_mean_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_embedding_bag_mean_unit_tb: self-checking bench for the unit
// Drives commands on the input stream and register writes over APB. A local
// model of the tables, the accumulator and the pooling arithmetic predicts
// each result not given by a directed vector, and every result transfer is
// compared against the expected results in order. Both stream sides idle at
// random, and one long output stall fills the unit.
module quantized_embedding_bag_mean_unit_tb;
  import qebm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 6;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] bkt;
    logic [5:0]  elem;
    logic [7:0]  bval;
    logic [31:0] scl;
    logic [31:0] accv;
    logic [7:0]  cnt;
    logic [6:0]  dlen;
  } command_s;

  typedef struct {
    logic [1:0]  sts;
    logic [31:0] rv;
  } outcome_s;

  typedef struct {
    command_s c;
    bit       typed;
    outcome_s r;
  } vector_s;

  logic                 clk, rst;
  logic                 s_tvalid, s_tready, m_tvalid, m_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 psel, penable, pwrite, pready;
  logic [3:0]           paddr;
  logic [31:0]          pwdata, prdata;

  // Local copy of the unit's state and registers.
  logic [7:0]  row_bytes [int];
  logic [31:0] bucket_scale [int];
  logic [31:0] acc_vec [64];
  int          cfg_size, cfg_buckets, cfg_bias;

  outcome_s pending_q[$];
  int errors, n_sent, n_results, n_pooled, cycles, hold_left;
  int pool [6] = '{0, 1, 2, 3, 2048, 4095};

  quantized_embedding_bag_mean_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Pooling arithmetic: exact 64-bit term, truncation toward zero, saturation.
  function automatic outcome_s pool_predict(command_s c);
    outcome_s o;
    longint   sc, term, sum;
    int       nb;
    o.sts = STS_OK;
    o.rv  = '0;
    case (c.op)
      OP_WR_BYTE:
        if (c.bkt < MAX_BUCKETS) row_bytes[c.bkt * 64 + c.elem] = c.bval;
        else o.sts = STS_RANGE;
      OP_WR_SCALE:
        if (c.bkt < MAX_BUCKETS) bucket_scale[c.bkt] = c.scl;
        else o.sts = STS_RANGE;
      OP_WR_ACC: acc_vec[c.elem] = c.accv;
      OP_ADD: begin
        nb = (cfg_buckets > MAX_BUCKETS) ? MAX_BUCKETS : cfg_buckets;
        if (c.dlen != cfg_size) o.sts = STS_LENGTH;
        else if (c.cnt == 0) o.sts = STS_COUNT;
        else if (c.bkt >= nb) o.sts = STS_RANGE;
        else begin
          sc = longint'(signed'(bucket_scale[c.bkt]));
          for (int k = 0; k < cfg_size && k < MAX_EMBED_SIZE; k++) begin
            term = (longint'(row_bytes[c.bkt * 64 + k]) - cfg_bias) * sc /
                   (64'sd16 * longint'(c.cnt));
            sum  = longint'(signed'(acc_vec[k])) + term;
            if (sum > 64'sh7fffffff) sum = 64'sh7fffffff;
            if (sum < -64'sh80000000) sum = -64'sh80000000;
            acc_vec[k] = sum[31:0];
          end
        end
      end
      OP_READ: o.rv = acc_vec[c.elem];
      default: ;
    endcase
    return o;
  endfunction

  // A bucket may be pooled only once its scale and every used byte are written.
  function automatic bit bucket_loaded(int b);
    if (!bucket_scale.exists(b)) return 0;
    for (int k = 0; k < cfg_size; k++)
      if (!row_bytes.exists(b * 64 + k)) return 0;
    return 1;
  endfunction

  function automatic command_s random_command();
    command_s c;
    int       pick, b;
    c.op = OP_READ; c.bkt = $urandom; c.elem = $urandom; c.bval = $urandom;
    c.scl = $urandom; c.accv = $urandom; c.cnt = $urandom; c.dlen = $urandom;
    case ($urandom_range(3))
      0: c.scl = 32'h7fffffff;
      1: c.scl = 32'h80000000;
      default: c.scl = $urandom_range(1, 32'h02000000) * ($urandom_range(1) ? 1 : -1);
    endcase
    if ($urandom_range(4) == 0) c.accv = $urandom_range(1) ? 32'h7ff00000 : 32'h80100000;
    b = pool[$urandom_range(5)];
    pick = $urandom_range(99);
    if (pick < 28) begin
      c.op = OP_WR_BYTE; c.bkt = b;
      if ($urandom_range(4) != 0) c.elem = $urandom_range(cfg_size - 1);
    end else if (pick < 36) begin
      c.op = OP_WR_SCALE; c.bkt = b;
    end else if (pick < 44) begin
      c.op = OP_WR_ACC;
    end else if (pick < 76) begin
      c.op = OP_ADD; c.bkt = b; c.dlen = cfg_size;
      c.cnt = $urandom_range(3) == 0 ? 1 : $urandom_range(1, 255);
      if (b >= cfg_buckets) ;
      else if (!bucket_loaded(b) || $urandom_range(5) == 0) begin
        case ($urandom_range(2))
          0: c.bkt = $urandom_range(cfg_buckets, 65535);
          1: c.cnt = 0;
          default: while (c.dlen == cfg_size) c.dlen = $urandom;
        endcase
        if (!bucket_loaded(c.bkt) && c.bkt < cfg_buckets && c.dlen == cfg_size
            && c.cnt != 0) c.cnt = 0;
      end
    end else if (pick < 92) begin
      c.op = OP_READ;
    end else begin
      // Unused opcodes and out-of-range table writes.
      c.op = $urandom_range(2) == 0 ? OP_WR_BYTE : $urandom_range(5, 7);
      c.bkt = $urandom_range(4096, 65535);
    end
    return c;
  endfunction

  // One command transfer; the prediction is queued when it is accepted.
  task automatic send_command(command_s c, bit typed, outcome_s r);
    outcome_s o;
    @(negedge clk);
    while ((n_sent < 250 || n_sent > 400) && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c.dlen, c.cnt, c.accv, c.scl, c.bval, c.elem, c.bkt, c.op};
    do @(posedge clk); while (!s_tready);
    o = pool_predict(c);
    if (c.op == OP_ADD && o.sts == STS_OK) n_pooled++;
    pending_q.push_back(typed ? r : o);
    n_sent++;
    if (n_sent == 150) hold_left = 400;
  endtask

  task automatic write_register(logic [1:0] idx, int value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
    case (idx)
      REG_EMBED_SIZE:  cfg_size = value;
      REG_NUM_BUCKETS: cfg_buckets = value;
      default:         cfg_bias = value;
    endcase
  endtask

  function automatic vector_s vec(logic [2:0] op, int bkt, int elem, int bval,
                                  logic [31:0] scl, logic [31:0] accv, int cnt,
                                  int dlen, bit typed, logic [1:0] sts,
                                  logic [31:0] rv);
    vector_s v;
    v.c = '{op, bkt, elem, bval, scl, accv, cnt, dlen};
    v.typed = typed;
    v.r = '{sts, rv};
    return v;
  endfunction

  // Output side: random stalls plus one long hold-off.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else m_tready <= !((n_sent < 250 || n_sent > 400) && $urandom_range(99) < 11);
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h", $time, m_tdata[1:0],
                 m_tdata[33:2]);
        errors++;
      end else begin
        if (m_tdata[1:0] !== pending_q[0].sts || m_tdata[33:2] !== pending_q[0].rv) begin
          $display("%0t: mismatch expected status=%0d value=%h actual status=%0d value=%h",
                   $time, pending_q[0].sts, pending_q[0].rv, m_tdata[1:0], m_tdata[33:2]);
          errors++;
        end
        void'(pending_q.pop_front());
        n_results++;
      end
    end
  end

  initial begin
    vector_s  dir [$];
    int       sizes [NUM_PHASES]   = '{64, 1, 8, 4, 64, 3};
    int       buckets [NUM_PHASES] = '{4096, 1, 4096, 4095, 2000, 4096};
    int       biases [NUM_PHASES]  = '{128, 0, 255, 127, 200, 1};
    int       counts [NUM_PHASES]  = '{40, 70, 110, 90, 120, 90};
    outcome_s none;

    rst = 1; s_tvalid = 0; s_tdata = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    hold_left = 0;
    cfg_size = 64; cfg_buckets = 4096; cfg_bias = 128;
    foreach (acc_vec[i]) acc_vec[i] = '0;
    none = '{STS_OK, 32'h0};
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed part: reset values, field extremes, every error path.
    dir.push_back(vec(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, STS_OK, 32'h0));
    dir.push_back(vec(OP_READ, 65535, 63, 255, '1, '1, 255, 127, 1, STS_OK, 32'h0));
    dir.push_back(vec(OP_WR_ACC, 0, 5, 0, 0, 32'h7fffffff, 0, 0, 1, STS_OK, 32'h0));
    dir.push_back(vec(OP_READ, 0, 5, 0, 0, 0, 0, 0, 1, STS_OK, 32'h7fffffff));
    dir.push_back(vec(OP_WR_ACC, 0, 6, 0, 0, 32'h80000000, 0, 0, 1, STS_OK, 32'h0));
    dir.push_back(vec(OP_READ, 0, 6, 0, 0, 0, 0, 0, 1, STS_OK, 32'h80000000));
    dir.push_back(vec(OP_WR_BYTE, 4095, 63, 255, 0, 0, 0, 0, 1, STS_OK, 32'h0));
    dir.push_back(vec(OP_WR_BYTE, 4096, 0, 1, 0, 0, 0, 0, 1, STS_RANGE, 32'h0));
    dir.push_back(vec(OP_WR_SCALE, 65535, 0, 0, 5, 0, 0, 0, 1, STS_RANGE, 32'h0));
    dir.push_back(vec(OP_WR_SCALE, 4095, 0, 0, 32'h7fffffff, 0, 0, 0, 1, STS_OK, 32'h0));
    dir.push_back(vec(OP_ADD, 0, 0, 0, 0, 0, 1, 63, 1, STS_LENGTH, 32'h0));
    dir.push_back(vec(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 1, STS_LENGTH, 32'h0));
    dir.push_back(vec(OP_ADD, 0, 0, 0, 0, 0, 0, 64, 1, STS_COUNT, 32'h0));
    dir.push_back(vec(OP_ADD, 4096, 0, 0, 0, 0, 1, 64, 1, STS_RANGE, 32'h0));
    dir.push_back(vec(OP_ADD, 65535, 0, 0, 0, 0, 255, 64, 1, STS_RANGE, 32'h0));
    dir.push_back(vec(3'd5, 1, 1, 1, 1, 1, 1, 1, 1, STS_OK, 32'h0));
    dir.push_back(vec(3'd6, 0, 0, 0, 0, 0, 0, 0, 1, STS_OK, 32'h0));
    dir.push_back(vec(3'd7, 65535, 63, 255, '1, '1, 255, 127, 1, STS_OK, 32'h0));
    dir.push_back(vec(OP_READ, 0, 63, 0, 0, 0, 0, 0, 0, STS_OK, 32'h0));
    foreach (dir[i]) send_command(dir[i].c, dir[i].typed, dir[i].r);

    // Random phases, each with its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      write_register(REG_EMBED_SIZE, sizes[p]);
      write_register(REG_NUM_BUCKETS, buckets[p]);
      write_register(REG_QUANT_BIAS, biases[p]);
      repeat (counts[p]) send_command(random_command(), 0, none);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Sent %0d commands over %0d register settings; %0d results checked.",
             n_sent, NUM_PHASES + 1, n_results);
    $display("Pooled features applied: %0d; mismatches: %0d.", n_pooled, errors);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
